[design/jhg_pkg.sv]
// Package for the JPEG header generator: field widths, mode codes, constant tables.
// Depends on nothing; used by every module of the block.
package jhg_pkg;

  localparam int unsigned PosW = 10;
  localparam int unsigned QstoreDepth = 128;
  localparam int unsigned FifoDepth = 4;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_EMIT = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  localparam logic [2:0] REG_FRAME_TYPE = 3'd0;
  localparam logic [2:0] REG_WIDTH = 3'd1;
  localparam logic [2:0] REG_HEIGHT = 3'd2;
  localparam logic [2:0] REG_QUALITY = 3'd3;
  localparam logic [2:0] REG_RESTART = 3'd4;
  localparam logic [2:0] REG_USE_LOADED = 3'd5;

  // Command passed from the front end to the byte builder: an emit or a store load
  typedef struct packed {
    logic [PosW-1:0] pos;
    logic            last;
    logic            load;
    logic [6:0]      addr;
    logic [7:0]      data;
  } emit_cmd_t;

  // Configuration seen by the byte builder
  typedef struct packed {
    logic        frame_type;
    logic [7:0]  width_blocks;
    logic [7:0]  height_blocks;
    logic [15:0] restart_interval;
    logic        use_loaded;
    logic [12:0] scale;
  } jhg_cfg_t;

  function automatic logic [6:0] base_luma(input logic [5:0] i);
    logic [6:0] t [64];
    t = '{7'd16,7'd11,7'd10,7'd16,7'd24,7'd40,7'd51,7'd61,7'd12,7'd12,7'd14,7'd19,7'd26,
          7'd58,7'd60,7'd55,7'd14,7'd13,7'd16,7'd24,7'd40,7'd57,7'd69,7'd56,7'd14,7'd17,
          7'd22,7'd29,7'd51,7'd87,7'd80,7'd62,7'd18,7'd22,7'd37,7'd56,7'd68,7'd109,7'd103,
          7'd77,7'd24,7'd35,7'd55,7'd64,7'd81,7'd104,7'd113,7'd92,7'd49,7'd64,7'd78,7'd87,
          7'd103,7'd121,7'd120,7'd101,7'd72,7'd92,7'd95,7'd98,7'd112,7'd100,7'd103,7'd99};
    return t[i];
  endfunction

  function automatic logic [6:0] base_chroma(input logic [5:0] i);
    logic [2:0] r;
    logic [2:0] c;
    logic [6:0] v;
    r = i[5:3];
    c = i[2:0];
    v = 7'd99;
    if (r == 3'd0) begin
      unique case (c)
        3'd0: v = 7'd17;
        3'd1: v = 7'd18;
        3'd2: v = 7'd24;
        3'd3: v = 7'd47;
        default: v = 7'd99;
      endcase
    end else if (r == 3'd1) begin
      unique case (c)
        3'd0: v = 7'd18;
        3'd1: v = 7'd21;
        3'd2: v = 7'd26;
        3'd3: v = 7'd66;
        default: v = 7'd99;
      endcase
    end else if (r == 3'd2) begin
      unique case (c)
        3'd0: v = 7'd24;
        3'd1: v = 7'd26;
        3'd2: v = 7'd56;
        default: v = 7'd99;
      endcase
    end else if (r == 3'd3) begin
      unique case (c)
        3'd0: v = 7'd47;
        3'd1: v = 7'd66;
        default: v = 7'd99;
      endcase
    end
    return v;
  endfunction

  function automatic logic [7:0] cnt_y_dc(input logic [3:0] i);
    logic [7:0] t [16];
    t = '{8'd0,8'd1,8'd5,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0};
    return t[i];
  endfunction

  function automatic logic [7:0] cnt_y_ac(input logic [3:0] i);
    logic [7:0] t [16];
    t = '{8'd0,8'd2,8'd1,8'd3,8'd3,8'd2,8'd4,8'd3,8'd5,8'd5,8'd4,8'd4,8'd0,8'd0,8'd1,8'h7d};
    return t[i];
  endfunction

  function automatic logic [7:0] cnt_c_dc(input logic [3:0] i);
    logic [7:0] t [16];
    t = '{8'd0,8'd3,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd0,8'd0,8'd0,8'd0,8'd0};
    return t[i];
  endfunction

  function automatic logic [7:0] cnt_c_ac(input logic [3:0] i);
    logic [7:0] t [16];
    t = '{8'd0,8'd2,8'd1,8'd2,8'd4,8'd4,8'd3,8'd4,8'd7,8'd5,8'd4,8'd4,8'd0,8'd1,8'd2,8'h77};
    return t[i];
  endfunction

  function automatic logic [7:0] val_y_ac(input logic [7:0] i);
    logic [7:0] t [162];
    t = '{8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,8'h13,
          8'h51,8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'ha1,8'h08,8'h23,8'h42,
          8'hb1,8'hc1,8'h15,8'h52,8'hd1,8'hf0,8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0a,
          8'h16,8'h17,8'h18,8'h19,8'h1a,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h34,8'h35,
          8'h36,8'h37,8'h38,8'h39,8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,
          8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,
          8'h68,8'h69,8'h6a,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'h83,8'h84,
          8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,
          8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,8'ha8,8'ha9,8'haa,8'hb2,8'hb3,
          8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,
          8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,8'hd9,8'hda,8'he1,
          8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf1,8'hf2,8'hf3,8'hf4,
          8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};
    return (i < 8'd162) ? t[i] : 8'd0;
  endfunction

  function automatic logic [7:0] val_c_ac(input logic [7:0] i);
    logic [7:0] t [162];
    t = '{8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,8'h05,8'h21,8'h31,8'h06,8'h12,8'h41,8'h51,
          8'h07,8'h61,8'h71,8'h13,8'h22,8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,8'ha1,8'hb1,
          8'hc1,8'h09,8'h23,8'h33,8'h52,8'hf0,8'h15,8'h62,8'h72,8'hd1,8'h0a,8'h16,8'h24,
          8'h34,8'he1,8'h25,8'hf1,8'h17,8'h18,8'h19,8'h1a,8'h26,8'h27,8'h28,8'h29,8'h2a,
          8'h35,8'h36,8'h37,8'h38,8'h39,8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,
          8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,
          8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'h82,
          8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,
          8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,8'ha8,8'ha9,8'haa,
          8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,8'hc4,8'hc5,
          8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,8'hd9,
          8'hda,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf2,8'hf3,8'hf4,
          8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};
    return (i < 8'd162) ? t[i] : 8'd0;
  endfunction

  function automatic logic [7:0] sos_byte(input logic [3:0] i);
    logic [7:0] t [16];
    t = '{8'hff,8'hda,8'h00,8'h0c,8'h03,8'h00,8'h00,8'h01,8'h11,8'h02,8'h11,8'h00,8'h3f,
          8'h00,8'h00,8'h00};
    return t[i];
  endfunction

  // 5000/q for q in 1..49, as a small table
  function automatic logic [12:0] low_scale(input logic [5:0] q);
    logic [12:0] t [64];
    t = '{13'd5000,13'd5000,13'd2500,13'd1666,13'd1250,13'd1000,13'd833,13'd714,13'd625,
          13'd555,13'd500,13'd454,13'd416,13'd384,13'd357,13'd333,13'd312,13'd294,13'd277,
          13'd263,13'd250,13'd238,13'd227,13'd217,13'd208,13'd200,13'd192,13'd185,13'd178,
          13'd172,13'd166,13'd161,13'd156,13'd151,13'd147,13'd142,13'd138,13'd135,13'd131,
          13'd128,13'd125,13'd121,13'd119,13'd116,13'd113,13'd111,13'd108,13'd106,13'd104,
          13'd102,13'd100,13'd100,13'd100,13'd100,13'd100,13'd100,13'd100,13'd100,13'd100,
          13'd100,13'd100,13'd100,13'd100,13'd100};
    return t[q];
  endfunction

endpackage

[design/jhg_front.sv]
// Front end: accepts items, keeps the header position and queues emit and store-load
// commands in arrival order. Depends on jhg_pkg.
module jhg_front
  import jhg_pkg::*;
#(
  parameter int unsigned Depth = FifoDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid,
  output logic            ready,
  input  logic [1:0]      mode,
  input  logic            table_select,
  input  logic [5:0]      entry_index,
  input  logic [7:0]      entry_value,
  input  logic            dri_on,
  output logic            q_wr,
  output logic [6:0]      q_addr,
  output logic [7:0]      q_data,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output emit_cmd_t       cmd
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [PosW-1:0] header_position;
  logic [PosW-1:0] total;
  emit_cmd_t       fifo [Depth];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     count;
  logic            take, push, pop, produce;

  assign total   = dri_on ? PosW'(611) : PosW'(605);
  assign ready   = (count != (AW+1)'(Depth));
  assign take    = valid && ready;
  assign produce = (mode == MODE_EMIT) && (header_position < total);
  assign push    = take && (produce || mode == MODE_LOAD);
  assign pop     = cmd_valid && cmd_ready;

  // Store loads leave the queue in order with the emits around them
  assign q_wr   = pop && cmd.load;
  assign q_addr = cmd.addr;
  assign q_data = cmd.data;

  // Advance or rewind the header position
  always_ff @(posedge clk) begin
    if (rst) begin
      header_position <= '0;
    end else if (take && mode == MODE_RESTART) begin
      header_position <= '0;
    end else if (take && produce) begin
      header_position <= header_position + PosW'(1);
    end
  end

  // Command queue
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr].pos  <= header_position;
      fifo[wr_ptr].last <= (header_position == total - PosW'(1));
      fifo[wr_ptr].load <= (mode == MODE_LOAD);
      fifo[wr_ptr].addr <= {table_select, entry_index};
      fifo[wr_ptr].data <= entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(Depth-1)) ? '0 : wr_ptr + AW'(1);
      if (pop)  rd_ptr <= (rd_ptr == AW'(Depth-1)) ? '0 : rd_ptr + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  assign cmd_valid = (count != '0);
  assign cmd       = fifo[rd_ptr];
endmodule

[design/jhg_back.sv]
// Back end: turns a header position into a byte through a two-stage pipe with the
// quantizer memory and derivation multiplier. Depends on jhg_pkg.
module jhg_back
  import jhg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  jhg_cfg_t   cfg,
  input  logic       q_wr,
  input  logic [6:0] q_addr,
  input  logic [7:0] q_data,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  emit_cmd_t  cmd,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] header_byte,
  output logic       last_byte
);
  logic [7:0]  qstore [QstoreDepth];
  logic [7:0]  q_rd;
  logic        s1_valid, s1_last, s1_isq;
  logic [7:0]  s1_byte;
  logic [19:0] s1_prod;
  logic        s1_adv, s2_adv;

  // Stage-0 decode
  logic [PosW-1:0] p, pd;
  logic [7:0]  b;
  logic        isq, tbl;
  logic [5:0]  qi;
  logic [PosW-1:0] off;
  logic [6:0]  base;
  logic [15:0] w, h;
  logic [15:0] q_sum;
  logic        q_sat;
  logic [7:0]  q_val;

  function automatic logic [7:0] dht(input logic [PosW-1:0] o, input logic [1:0] k);
    logic [7:0] r;
    logic [PosW-1:0] v;
    r = 8'd0;
    v = o - PosW'(21);
    if (o == PosW'(0)) r = 8'hff;
    else if (o == PosW'(1)) r = 8'hc4;
    else if (o == PosW'(2)) r = 8'h00;
    else if (o == PosW'(3)) r = k[0] ? 8'd181 : 8'd31;
    else if (o == PosW'(4)) r = {3'd0, k[0], 3'd0, k[1]};
    else if (o < PosW'(21)) begin
      unique case (k)
        2'd0: r = cnt_y_dc(4'(o - PosW'(5)));
        2'd1: r = cnt_y_ac(4'(o - PosW'(5)));
        2'd2: r = cnt_c_dc(4'(o - PosW'(5)));
        default: r = cnt_c_ac(4'(o - PosW'(5)));
      endcase
    end else if (!k[0]) begin
      r = (v < PosW'(12)) ? {4'd0, v[3:0]} : 8'd0;
    end else if (k[1]) begin
      r = val_c_ac(v[7:0]);
    end else begin
      r = val_y_ac(v[7:0]);
    end
    return r;
  endfunction

  assign s2_adv    = !out_valid || out_ready;
  assign s1_adv    = !s1_valid || s2_adv;
  assign cmd_ready = s1_adv;

  always_comb begin
    p   = cmd.pos;
    b   = 8'd0;
    isq = 1'b0;
    tbl = 1'b0;
    qi  = '0;
    off = '0;
    pd  = '0;
    w   = {5'd0, cfg.width_blocks, 3'd0};
    h   = {5'd0, cfg.height_blocks, 3'd0};
    if (p < PosW'(2)) begin
      b = p[0] ? 8'hd8 : 8'hff;
    end else if (p < PosW'(140)) begin
      tbl = (p >= PosW'(71));
      off = tbl ? p - PosW'(71) : p - PosW'(2);
      priority case (1'b1)
        off == PosW'(0): b = 8'hff;
        off == PosW'(1): b = 8'hdb;
        off == PosW'(2): b = 8'h00;
        off == PosW'(3): b = 8'd67;
        off == PosW'(4): b = {7'd0, tbl};
        default: begin
          isq = 1'b1;
          qi  = 6'(off - PosW'(5));
        end
      endcase
    end else begin
      pd = p - PosW'(140);
      if (cfg.restart_interval != 16'd0 && pd < PosW'(6)) begin
        unique case (pd[2:0])
          3'd0: b = 8'hff;
          3'd1: b = 8'hdd;
          3'd2: b = 8'h00;
          3'd3: b = 8'h04;
          3'd4: b = cfg.restart_interval[15:8];
          default: b = cfg.restart_interval[7:0];
        endcase
      end else begin
        if (cfg.restart_interval != 16'd0) pd = pd - PosW'(6);
        if (pd < PosW'(19)) begin
          unique case (pd[4:0])
            5'd0: b = 8'hff;
            5'd1: b = 8'hc0;
            5'd2: b = 8'h00;
            5'd3: b = 8'd17;
            5'd4: b = 8'd8;
            5'd5: b = h[15:8];
            5'd6: b = h[7:0];
            5'd7: b = w[15:8];
            5'd8: b = w[7:0];
            5'd9: b = 8'd3;
            5'd10: b = 8'd0;
            5'd11: b = cfg.frame_type ? 8'h22 : 8'h21;
            5'd12: b = 8'd0;
            5'd13: b = 8'd1;
            5'd14: b = 8'h11;
            5'd15: b = 8'd1;
            5'd16: b = 8'd2;
            5'd17: b = 8'h11;
            default: b = 8'd1;
          endcase
        end else if (pd < PosW'(52)) begin
          off = pd - PosW'(19);
          b = dht(off, 2'd0);
        end else if (pd < PosW'(235)) begin
          off = pd - PosW'(52);
          b = dht(off, 2'd1);
        end else if (pd < PosW'(268)) begin
          off = pd - PosW'(235);
          b = dht(off, 2'd2);
        end else if (pd < PosW'(451)) begin
          off = pd - PosW'(268);
          b = dht(off, 2'd3);
        end else begin
          off = pd - PosW'(451);
          b = (off < PosW'(14)) ? sos_byte(off[3:0]) : 8'd0;
        end
      end
    end
    base = tbl ? base_chroma(qi) : base_luma(qi);
  end

  // Quantizer memory
  always_ff @(posedge clk) begin
    if (q_wr) qstore[q_addr] <= q_data;
  end
  always_ff @(posedge clk) begin
    if (s1_adv) q_rd <= qstore[{tbl, qi}];
  end

  // Stage 1: register decoded byte and product; loads end at the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= cmd_valid && !cmd.load;
    end
  end
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_byte <= b;
      s1_last <= cmd.last;
      s1_isq  <= isq;
      s1_prod <= 20'(base) * 20'(cfg.scale);
    end
  end

  // Saturate large products, else rounded divide by 100 via (x*5243)>>19,
  // exact for x < 2^15
  always_comb begin
    q_sat = (s1_prod > 20'd25549);
    q_sum = q_sat ? 16'd0 : 16'(s1_prod) + 16'd50;
  end
  logic [29:0] recip;
  logic [10:0] quo;
  assign recip = 30'(q_sum) * 30'd5243;
  assign quo   = recip[29:19];
  always_comb begin
    if (q_sat) q_val = 8'd255;
    else if (quo == 11'd0) q_val = 8'd1;
    else if (quo > 11'd255) q_val = 8'd255;
    else q_val = quo[7:0];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= s1_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (s2_adv) begin
      header_byte <= !s1_isq ? s1_byte : (cfg.use_loaded ? q_rd : q_val);
      last_byte   <= s1_last;
    end
  end
endmodule

[design/jpeg_header_generator.sv]
// Top level of the JPEG header generator: configuration registers, scale setup,
// front end, command queue and byte builder. Depends on jhg_pkg, jhg_front, jhg_back.
//
// Takes one item per clock while the queue has room and returns one header byte per emit
// request within the header, one byte a cycle unless the output stalls; a byte passes
// through the queue, then decode with the quantizer memory read and multiply, then
// divide-by-100 into the output register. Store loads travel through the same queue, so
// they stay in order with the emits around them. Header is 605 bytes, 611 when the
// restart interval is nonzero. The scale (a table entry below quality 50) is formed in
// the cycle after a quality write. Loaded quantizer entries are undefined until written.
module jpeg_header_generator
  import jhg_pkg::*;
#(
  parameter int unsigned QueueDepth = FifoDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        valid,
  output logic        ready,
  input  logic [1:0]  mode,
  input  logic        table_select,
  input  logic [5:0]  entry_index,
  input  logic [7:0]  entry_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  header_byte,
  output logic        last_byte
);
  jhg_cfg_t   cfg;
  logic [7:0] quality;
  logic [6:0] qc;
  logic       q_wr, cmd_valid, cmd_ready;
  logic [6:0] q_addr;
  logic [7:0] q_data;
  emit_cmd_t  cmd;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_type       <= 1'b0;
      cfg.width_blocks     <= 8'd0;
      cfg.height_blocks    <= 8'd0;
      cfg.restart_interval <= 16'd0;
      cfg.use_loaded       <= 1'b0;
      quality              <= 8'd50;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_TYPE: cfg.frame_type <= cfg_data[0];
        REG_WIDTH:      cfg.width_blocks <= cfg_data[7:0];
        REG_HEIGHT:     cfg.height_blocks <= cfg_data[7:0];
        REG_QUALITY:    quality <= cfg_data[7:0];
        REG_RESTART:    cfg.restart_interval <= cfg_data;
        REG_USE_LOADED: cfg.use_loaded <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp quality and form the scale
  assign qc = (quality == 8'd0) ? 7'd1 : (quality > 8'd99) ? 7'd99 : quality[6:0];
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale <= 13'd100;
    end else begin
      cfg.scale <= (qc < 7'd50) ? low_scale(qc[5:0])
                                : 13'(8'd200 - {qc, 1'b0});
    end
  end

  jhg_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst, .valid, .ready, .mode, .table_select, .entry_index, .entry_value,
    .dri_on(cfg.restart_interval != 16'd0),
    .q_wr, .q_addr, .q_data, .cmd_valid, .cmd_ready, .cmd
  );

  jhg_back u_back (
    .clk, .rst, .cfg, .q_wr, .q_addr, .q_data, .cmd_valid, .cmd_ready, .cmd,
    .out_valid, .out_ready, .header_byte, .last_byte
  );
endmodule

[design/jhg_checker.sv]
// Port-level checker for the JPEG header generator, bound to the top level.
// Depends on jhg_pkg.
module jhg_checker
  import jhg_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] header_byte,
  input logic       last_byte
);
  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(header_byte))
    else $error("stalled result changed");

  // No result right after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  // The final byte of SOS is zero
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_byte |-> header_byte == 8'h00)
    else $error("last byte not zero");

  // The input is open as soon as reset drops
  a_open: assert property (@(posedge clk) $fell(rst) |-> ready)
    else $error("input closed after reset");
endmodule

bind jpeg_header_generator jhg_checker u_chk (
  .clk, .rst, .ready, .out_valid, .out_ready, .header_byte, .last_byte
);
